/* rtl/unit_group_cayley_table_unit_defines.svh */
// Assertion shorthands for the unit group table block.
// Each expects clk_i and rst_ni in scope.
`ifndef UNIT_GROUP_CAYLEY_TABLE_UNIT_DEFINES_SVH
`define UNIT_GROUP_CAYLEY_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define UCG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ucg_pkg.sv */
package ucg_pkg;

  localparam int unsigned VAL_W  = 9;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned STEP_W = $clog2(PROD_W + 1);

  localparam logic CMD_BUILD  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [VAL_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } rem_rsp_t;

endpackage

/* rtl/unit_group_cayley_table_unit.sv */
// Unit group table block: lists the units modulo n and looks up their products.
// Input stream: s_axis_tuser selects build (0) or lookup (1); s_axis_tdata
// carries row and column positions. Output stream: one transaction per input,
// m_axis_tdata carries the unit count and 1-based product position,
// m_axis_tuser the status (ok, index out of range, list not built).
// cfg_data_i sets the modulus and is taken only while idle; a write drops the list.
// One transaction is worked at a time; s_axis_tready is high only when idle
// and no configuration write is offered.
// All modulo arithmetic runs through one restoring remainder unit that takes
// one quotient bit per cycle. Build: runs Euclid's algorithm on n and each
// candidate 1..n-1 in turn and stores every unit found, so the list ascends.
// Lookup: reads both list entries, multiplies them, reduces the product modulo
// n and binary searches the ascending list (at most 8 probes). Error results
// go straight to the final state.
// Reset clears the list valid flag and count and sets the modulus to 1.
// A finished result waits in the output register while the receiver stalls;
// the block holds in its final state until that register is free.
`include "unit_group_cayley_table_unit_defines.svh"

module unit_group_cayley_table_unit import ucg_pkg::*; #(
  parameter int unsigned MAX_MODULUS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row_index[7:0], column_index[15:8]
  input  logic        s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // unit_count[7:0], entry_index[15:8]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned DEPTH = (MAX_MODULUS < 512) ? MAX_MODULUS : 512;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    IDLE, B_ONE, G_START, G_WAIT, B_STORE, B_NEXT,
    L_ROW, L_COL, L_MUL, M_START, M_WAIT, S_PROBE, S_CMP, FINISH
  } state_e;

  state_e            state_q;
  logic [8:0]        modulus_q;
  logic              built_q;
  logic [AW-1:0]     count_q;
  logic [VAL_W-1:0]  n_q, x_q, y_q, v_q, a_q, target_q;
  logic [PROD_W-1:0] prod_q;
  logic [7:0]        row_q, col_q;
  logic [AW-1:0]     lo_q, hi_q, mid_q;
  logic [7:0]        res_cnt_q, res_ent_q;
  logic [1:0]        res_st_q;
  logic              m_valid_q;
  logic [15:0]       m_data_q;
  logic [1:0]        m_user_q;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata_q;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;
  logic [VAL_W-1:0]  wdata;

  logic [VAL_W-1:0]  eff_n;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic              s_acc;
  logic              row_bad;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  assign s_axis_tready = (state_q == IDLE) && !cfg_valid_i;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    if (modulus_q == '0) begin
      eff_n = VAL_W'(1);
    end else if (32'(modulus_q) > MAX_MODULUS) begin
      eff_n = VAL_W'(MAX_MODULUS);
    end else begin
      eff_n = modulus_q;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[AW:1];
  assign row_bad = (VAL_W'(s_axis_tdata[7:0]) >= VAL_W'(count_q)) ||
                   (VAL_W'(s_axis_tdata[15:8]) >= VAL_W'(count_q));

  always_comb begin
    mem_we = (state_q == B_STORE) || (state_q == B_ONE);
    waddr  = (state_q == B_ONE) ? '0 : count_q;
    wdata  = (state_q == B_ONE) ? VAL_W'(1) : v_q;
    unique case (state_q)
      L_ROW:   raddr = AW'(row_q);
      L_COL:   raddr = AW'(col_q);
      default: raddr = mid;
    endcase
    rem_req.start    = (state_q == G_START) || (state_q == M_START);
    rem_req.dividend = (state_q == M_START) ? prod_q : PROD_W'(x_q);
    rem_req.divisor  = (state_q == M_START) ? n_q : y_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  ucg_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      modulus_q <= 9'd1;
      built_q   <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != FINISH)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (cfg_valid_i) begin
            modulus_q <= cfg_data_i;
            built_q   <= 1'b0;
            count_q   <= '0;
          end else if (s_acc) begin
            row_q <= s_axis_tdata[7:0];
            col_q <= s_axis_tdata[15:8];
            n_q   <= eff_n;
            if (s_axis_tuser == CMD_BUILD) begin
              built_q <= 1'b0;
              count_q <= '0;
              if (eff_n == VAL_W'(1)) begin
                state_q <= B_ONE;
              end else begin
                x_q     <= eff_n;
                y_q     <= VAL_W'(1);
                v_q     <= VAL_W'(1);
                state_q <= G_START;
              end
            end else if (!built_q) begin
              res_cnt_q <= '0;
              res_ent_q <= '0;
              res_st_q  <= ST_NOT_BUILT;
              state_q   <= FINISH;
            end else if (row_bad) begin
              res_cnt_q <= 8'(count_q);
              res_ent_q <= '0;
              res_st_q  <= ST_RANGE;
              state_q   <= FINISH;
            end else begin
              state_q <= L_ROW;
            end
          end
        end
        B_ONE: begin
          count_q   <= AW'(1);
          built_q   <= 1'b1;
          res_cnt_q <= 8'd1;
          res_ent_q <= '0;
          res_st_q  <= ST_OK;
          state_q   <= FINISH;
        end
        G_START: begin
          state_q <= G_WAIT;
        end
        G_WAIT: begin
          if (rem_rsp.done) begin
            x_q <= y_q;
            y_q <= rem_rsp.rem;
            if (rem_rsp.rem == '0) begin
              state_q <= (y_q == VAL_W'(1)) ? B_STORE : B_NEXT;
            end else begin
              state_q <= G_START;
            end
          end
        end
        B_STORE: begin
          count_q <= count_q + AW'(1);
          state_q <= B_NEXT;
        end
        B_NEXT: begin
          if (v_q == n_q - VAL_W'(1)) begin
            built_q   <= 1'b1;
            res_cnt_q <= 8'(count_q);
            res_ent_q <= '0;
            res_st_q  <= ST_OK;
            state_q   <= FINISH;
          end else begin
            v_q     <= v_q + VAL_W'(1);
            x_q     <= n_q;
            y_q     <= v_q + VAL_W'(1);
            state_q <= G_START;
          end
        end
        L_ROW: begin
          state_q <= L_COL;
        end
        L_COL: begin
          a_q     <= rdata_q;
          state_q <= L_MUL;
        end
        L_MUL: begin
          prod_q  <= PROD_W'(a_q) * PROD_W'(rdata_q);
          state_q <= M_START;
        end
        M_START: begin
          state_q <= M_WAIT;
        end
        M_WAIT: begin
          if (rem_rsp.done) begin
            target_q <= rem_rsp.rem;
            lo_q     <= '0;
            hi_q     <= count_q;
            state_q  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo_q >= hi_q) begin
            res_cnt_q <= 8'(count_q);
            res_ent_q <= '0;
            res_st_q  <= ST_OK;
            state_q   <= FINISH;
          end else begin
            mid_q   <= mid;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata_q == target_q) begin
            res_cnt_q <= 8'(count_q);
            res_ent_q <= 8'(mid_q + AW'(1));
            res_st_q  <= ST_OK;
            state_q   <= FINISH;
          end else begin
            if (rdata_q < target_q) begin
              lo_q <= mid_q + AW'(1);
            end else begin
              hi_q <= mid_q;
            end
            state_q <= S_PROBE;
          end
        end
        FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_ent_q, res_cnt_q};
            m_user_q  <= res_st_q;
            state_q   <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  `UCG_ASSERT_IMP(a_rem_done_in_wait, rem_rsp.done,
                  (state_q == G_WAIT) || (state_q == M_WAIT),
                  "remainder result outside a wait state")
  `UCG_ASSERT_IMP(a_write_unbuilt, mem_we, !built_q,
                  "list written while marked built")
  `UCG_ASSERT_IMP(a_probe_in_range, state_q == S_CMP, lo_q < hi_q,
                  "search probe outside bounds")
  `UCG_ASSERT_NXT(a_accept_leaves_idle, s_acc, state_q != IDLE,
                  "accepted transaction not started")

endmodule

/* rtl/ucg_rem.sv */
module ucg_rem import ucg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [PROD_W-1:0] num_q;
  logic [VAL_W-1:0]  den_q;
  logic [VAL_W-1:0]  rem_q;

  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic [VAL_W-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, num_q[PROD_W-1]};
    diff  = trial - {1'b0, den_q};
    rem_d = diff[VAL_W] ? trial[VAL_W-1:0] : diff[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(PROD_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[PROD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
